### rtl/rkc_pkg.sv
// Shared types, constants and helpers for the rotary knob controller.
package rkc_pkg;

  // Field widths.
  localparam int FUNC_W     = 3;
  localparam int TIME_BITS  = 32;
  localparam int POS_W      = 16;
  localparam int LEVEL_W    = 8;
  localparam int DUTY_W     = 16;
  localparam int PERIOD_W   = 20;
  localparam int NUM_COLORS = 3;

  // Reset values.
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(10000);
  localparam logic [DUTY_W-1:0]   DUTY_OFF     = {DUTY_W{1'b1}};

  // Stream widths.
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 88;

  // Event codes.
  localparam logic EVT_BUTTON   = 1'b0;
  localparam logic EVT_POSITION = 1'b1;

  // Command codes carried in the input tuser.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_SAMPLE     = 3'd0,
    FUNC_GET_BUTTON = 3'd1,
    FUNC_GET_POS    = 3'd2,
    FUNC_ADD_OFFSET = 3'd3,
    FUNC_SET_COLOR  = 3'd4,
    FUNC_GET_EVENT  = 3'd5,
    FUNC_CLR_EVENT  = 3'd6,
    FUNC_RESET      = 3'd7
  } func_t;

  typedef logic [DUTY_W-1:0] duty_t;

  // One input beat, unpacked.
  typedef struct packed {
    func_t                func;
    logic                 pin_a;
    logic                 pin_b;
    logic                 pin_sw;
    logic [TIME_BITS-1:0] time_us;
    logic [POS_W-1:0]     offset;
    logic [LEVEL_W-1:0]   red_level;
    logic [LEVEL_W-1:0]   green_level;
    logic [LEVEL_W-1:0]   blue_level;
    logic                 clear_code;
  } item_t;

  // Per-beat strobes from the command decode to the state blocks.
  typedef struct packed {
    logic sample;
    logic add_offset;
    logic reset_count;
    logic clear_position;
    logic clear_buttons;
    logic set_color;
    logic reset_color;
  } cmd_t;

  // Inverted gamma: full scale minus the square of the level.
  function automatic duty_t gamma_duty(input logic [LEVEL_W-1:0] level);
    logic [DUTY_W-1:0] sq;
    sq = DUTY_W'(level) * DUTY_W'(level);
    return DUTY_OFF - sq;
  endfunction

endpackage

### rtl/rkc_encoder.sv
// Quadrature decoder count and reported position with change flag.
module rkc_encoder (
  input  logic                     clk,
  input  logic                     rst_n,
  input  rkc_pkg::cmd_t            cmd,
  input  logic                     pin_a,
  input  logic                     pin_b,
  input  logic [rkc_pkg::POS_W-1:0] offset,
  output logic [rkc_pkg::POS_W-1:0] position,
  output logic                     position_changed
);
  import rkc_pkg::*;

  logic             prev_a_r, prev_a_nxt;
  logic [POS_W-1:0] count_r, count_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             changed_r, changed_nxt;
  logic [POS_W-1:0] stepped;
  logic [POS_W-1:0] neg_pos;

  // Count on A edges while B is low; the position is the negated count.
  always_comb begin
    stepped = count_r;
    if (!pin_b && pin_a && !prev_a_r) begin
      stepped = count_r + POS_W'(1);
    end else if (!pin_b && !pin_a && prev_a_r) begin
      stepped = count_r - POS_W'(1);
    end
    neg_pos = POS_W'(0) - stepped;

    prev_a_nxt  = prev_a_r;
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    changed_nxt = changed_r;
    if (cmd.sample) begin
      prev_a_nxt = pin_a;
      count_nxt  = stepped;
      if (neg_pos != pos_r) begin
        pos_nxt     = neg_pos;
        changed_nxt = 1'b1;
      end
    end
    if (cmd.add_offset) begin
      count_nxt = count_r + offset;
    end
    if (cmd.reset_count) begin
      count_nxt = '0;
    end
    if (cmd.clear_position) begin
      changed_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_a_r  <= 1'b0;
      count_r   <= '0;
      pos_r     <= '0;
      changed_r <= 1'b0;
    end else begin
      prev_a_r  <= prev_a_nxt;
      count_r   <= count_nxt;
      pos_r     <= pos_nxt;
      changed_r <= changed_nxt;
    end
  end

  assign position         = pos_r;
  assign position_changed = changed_r;

endmodule

### rtl/rkc_switch.sv
// Push switch debounce, button level and latched press/release flags.
module rkc_switch (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [rkc_pkg::PERIOD_W-1:0]  cfg_wr_data,
  input  rkc_pkg::cmd_t                 cmd,
  input  logic                          pin_sw,
  input  logic [rkc_pkg::TIME_BITS-1:0] time_us,
  output logic                          button_level,
  output logic                          pressed,
  output logic                          released
);
  import rkc_pkg::*;

  logic [PERIOD_W-1:0]  period_r;
  logic                 deb_r, deb_nxt;
  logic [TIME_BITS-1:0] start_r, start_nxt;
  logic                 button_r, button_nxt;
  logic                 pressed_r, pressed_nxt;
  logic                 released_r, released_nxt;
  logic [TIME_BITS:0]   deadline;

  // Debounce period register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
    end else if (cfg_wr_en) begin
      period_r <= cfg_wr_data;
    end
  end

  // A differing level is taken once the sample time passes the deadline.
  // Timestamp wrap is not handled.
  always_comb begin
    deadline     = {1'b0, start_r} + (TIME_BITS+1)'(period_r);
    deb_nxt      = deb_r;
    start_nxt    = start_r;
    button_nxt   = button_r;
    pressed_nxt  = pressed_r;
    released_nxt = released_r;
    if (cmd.sample) begin
      if (pin_sw == deb_r) begin
        start_nxt = time_us;
      end else if ({1'b0, time_us} > deadline) begin
        deb_nxt   = pin_sw;
        start_nxt = '0;
      end
      if (!button_r && deb_nxt) begin
        pressed_nxt = 1'b1;
      end
      if (button_r && !deb_nxt) begin
        released_nxt = 1'b1;
      end
      button_nxt = deb_nxt;
    end
    if (cmd.clear_buttons) begin
      pressed_nxt  = 1'b0;
      released_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_r      <= 1'b0;
      start_r    <= '0;
      button_r   <= 1'b0;
      pressed_r  <= 1'b0;
      released_r <= 1'b0;
    end else begin
      deb_r      <= deb_nxt;
      start_r    <= start_nxt;
      button_r   <= button_nxt;
      pressed_r  <= pressed_nxt;
      released_r <= released_nxt;
    end
  end

  assign button_level = button_r;
  assign pressed      = pressed_r;
  assign released     = released_r;

endmodule

### rtl/rkc_color.sv
// RGB duty registers with inverted gamma mapping.
module rkc_color (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  rkc_pkg::cmd_t                              cmd,
  input  logic [rkc_pkg::LEVEL_W-1:0]                red_level,
  input  logic [rkc_pkg::LEVEL_W-1:0]                green_level,
  input  logic [rkc_pkg::LEVEL_W-1:0]                blue_level,
  output rkc_pkg::duty_t [rkc_pkg::NUM_COLORS-1:0]   duty_nxt
);
  import rkc_pkg::*;

  duty_t [NUM_COLORS-1:0] duty_r;

  // Next duties; the result beat reports them after the command acts.
  always_comb begin
    duty_nxt = duty_r;
    if (cmd.set_color) begin
      duty_nxt[0] = gamma_duty(red_level);
      duty_nxt[1] = gamma_duty(green_level);
      duty_nxt[2] = gamma_duty(blue_level);
    end
    if (cmd.reset_color) begin
      duty_nxt = {NUM_COLORS{DUTY_OFF}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r <= {NUM_COLORS{DUTY_OFF}};
    end else begin
      duty_r <= duty_nxt;
    end
  end

endmodule

### rtl/rotary_knob_controller.sv
// Top level of the rotary knob controller: stream ports, command decode, stages.
//
// Each input beat is either a pin sample (quadrature pins, push switch and a
// microsecond timestamp) or a bus command, selected by the code in in_tuser.
// Every accepted input beat produces exactly one result beat, in order.
// The beat is captured in an input register; once the output register can take
// a result, the command is decoded, the decoder, switch and color state are
// updated and the result is loaded into the output register, which drives
// out_tvalid. Throughput is one beat per cycle while out_tready stays high,
// set by the single update stage. When out_tready is low the finished result
// holds in the output register and the input register still takes one more
// beat; in_tready drops only when both are full. The debounce period is written
// through cfg_wr_en/cfg_wr_data; the user must write it only while the block is
// idle, which the block itself does not enforce. Synchronous reset (rst_n low)
// empties both stages, clears the count, position, switch state and flags, sets
// all duties to full scale and the debounce period to 10000 us.
module rotary_knob_controller (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [rkc_pkg::PERIOD_W-1:0]   cfg_wr_data,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // pin_a[0], pin_b[1], pin_sw[2], time_us[34:3], offset[50:35],
  // red_level[58:51], green_level[66:59], blue_level[74:67], clear_code[75]
  input  logic [rkc_pkg::IN_DATA_W-1:0]  in_tdata,
  // func[2:0]
  input  logic [rkc_pkg::FUNC_W-1:0]     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // ok[0], read_data[16:1], event_valid[17], event_data[33:18],
  // duty_red[49:34], duty_green[65:50], duty_blue[81:66]
  output logic [rkc_pkg::OUT_DATA_W-1:0] out_tdata,
  // event_code[0]
  output logic                           out_tuser
);
  import rkc_pkg::*;

  logic                   s1_valid_r;
  item_t                  s1_item_r;
  logic                   out_valid_r;
  logic [OUT_DATA_W-1:0]  out_data_r;
  logic                   out_user_r;
  logic                   advance;
  logic                   fire;
  cmd_t                   cmd;
  logic [POS_W-1:0]       position;
  logic                   position_changed;
  logic                   button_level;
  logic                   pressed;
  logic                   released;
  duty_t [NUM_COLORS-1:0] duty_nxt;
  logic [POS_W-1:0]       read_data;
  logic                   evt_valid;
  logic                   evt_code;
  logic [POS_W-1:0]       evt_data;

  // Stage handshake.
  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.func        <= func_t'(in_tuser);
      s1_item_r.pin_a       <= in_tdata[0];
      s1_item_r.pin_b       <= in_tdata[1];
      s1_item_r.pin_sw      <= in_tdata[2];
      s1_item_r.time_us     <= in_tdata[34:3];
      s1_item_r.offset      <= in_tdata[50:35];
      s1_item_r.red_level   <= in_tdata[58:51];
      s1_item_r.green_level <= in_tdata[66:59];
      s1_item_r.blue_level  <= in_tdata[74:67];
      s1_item_r.clear_code  <= in_tdata[75];
    end
  end

  // Command decode into state strobes.
  always_comb begin
    cmd = '0;
    if (fire) begin
      case (s1_item_r.func)
        FUNC_SAMPLE:     cmd.sample = 1'b1;
        FUNC_ADD_OFFSET: cmd.add_offset = 1'b1;
        FUNC_SET_COLOR:  cmd.set_color = 1'b1;
        FUNC_CLR_EVENT: begin
          cmd.clear_buttons  = (s1_item_r.clear_code == EVT_BUTTON);
          cmd.clear_position = (s1_item_r.clear_code == EVT_POSITION);
        end
        FUNC_RESET: begin
          cmd.reset_count = 1'b1;
          cmd.reset_color = 1'b1;
        end
        default: cmd = '0;
      endcase
    end
  end

  rkc_encoder u_encoder (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .pin_a            (s1_item_r.pin_a),
    .pin_b            (s1_item_r.pin_b),
    .offset           (s1_item_r.offset),
    .position         (position),
    .position_changed (position_changed)
  );

  rkc_switch u_switch (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .cmd          (cmd),
    .pin_sw       (s1_item_r.pin_sw),
    .time_us      (s1_item_r.time_us[TIME_BITS-1:0]),
    .button_level (button_level),
    .pressed      (pressed),
    .released     (released)
  );

  rkc_color u_color (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .red_level   (s1_item_r.red_level),
    .green_level (s1_item_r.green_level),
    .blue_level  (s1_item_r.blue_level),
    .duty_nxt    (duty_nxt)
  );

  // Read and event fields, taken from the state before this command acts.
  always_comb begin
    read_data = '0;
    evt_valid = 1'b0;
    evt_code  = EVT_BUTTON;
    evt_data  = '0;
    case (s1_item_r.func)
      FUNC_GET_BUTTON: read_data = POS_W'(button_level);
      FUNC_GET_POS:    read_data = position;
      FUNC_GET_EVENT: begin
        if (pressed || released) begin
          evt_valid = 1'b1;
          evt_code  = EVT_BUTTON;
          evt_data  = {7'd0, pressed, 7'd0, released};
        end else if (position_changed) begin
          evt_valid = 1'b1;
          evt_code  = EVT_POSITION;
          evt_data  = position;
        end
      end
      default: read_data = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= {6'd0, duty_nxt[2], duty_nxt[1], duty_nxt[0],
                     evt_data, evt_valid, read_data, 1'b1};
      out_user_r <= evt_code;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

### sim/rotary_knob_controller_tb.sv
// Self-checking testbench for the rotary knob controller with a built-in knob predictor.
`timescale 1ns / 100ps

module rotary_knob_controller_tb;
  import rkc_pkg::*;

  localparam int LONG_HOLD   = 60;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASE_BEATS = 215;

  // One result beat, unpacked.
  typedef struct packed {
    logic        ok;
    logic [15:0] read_data;
    logic        ev_valid;
    logic        ev_code;
    logic [15:0] ev_data;
    logic [15:0] duty_r;
    logic [15:0] duty_g;
    logic [15:0] duty_b;
  } knob_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [PERIOD_W-1:0]   cfg_wr_data = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [FUNC_W-1:0]     in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;

  // Predicted knob state.
  logic [PERIOD_W-1:0] period_now;
  logic                prev_a;
  logic [15:0]         count_now;
  logic [15:0]         position_now;
  logic                pos_changed;
  logic                deb_level;
  logic [31:0]         change_start;
  logic                button_now;
  logic                pressed_now;
  logic                released_now;
  logic [15:0]         duty_now [3];

  // Stimulus generator state: a knob turned by hand with a bouncy switch.
  logic [31:0] stamp;
  int          quad_phase;
  int          turn_dir;
  logic        sw_level;
  int          bounce_left;

  // Queues, handshake bookkeeping and counters.
  item_t        beats_to_send [$];
  knob_result_t replies_due [$];
  item_t        offered_item;
  logic         in_beat = 1'b0;
  logic         out_beat = 1'b0;
  int           gap_left = 0;
  int           stall_left = 0;
  int           hold_left = 0;
  int           gap_max = 10;
  int           stall_max = 10;
  int           holds_asked = 0;
  int           holds_granted = 0;
  int           queued_beats = 0;
  int           accepted_beats = 0;
  int           quiet_cycles = 0;
  int           mismatches = 0;
  int           sample_beats = 0;
  int           button_events = 0;
  int           position_events = 0;
  int           settings_used = 1;

  rotary_knob_controller i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Inverted gamma: full scale minus the square of the 8-bit level.
  function automatic logic [15:0] level_to_duty(logic [7:0] level);
    return DUTY_OFF - (16'(level) * 16'(level));
  endfunction

  // Applies one beat to the predicted state and returns the result it must produce.
  function automatic knob_result_t advance_knob(item_t it);
    knob_result_t r;
    logic [15:0]  next_pos;
    r = '0;
    r.ok = 1'b1;
    case (it.func)
      FUNC_SAMPLE: begin
        sample_beats++;
        // Count only while B is low: A rising steps up, A falling steps down.
        if (!it.pin_b) begin
          if (it.pin_a && !prev_a) count_now = count_now + 16'd1;
          if (!it.pin_a && prev_a) count_now = count_now - 16'd1;
        end
        prev_a = it.pin_a;
        // A differing switch level must outlast the debounce period.
        if (it.pin_sw == deb_level) begin
          change_start = it.time_us;
        end else if ({32'b0, it.time_us} > {32'b0, change_start} + 64'(period_now)) begin
          deb_level = it.pin_sw;
          change_start = '0;
        end
        next_pos = 16'd0 - count_now;
        if (next_pos != position_now) begin
          pos_changed = 1'b1;
          position_now = next_pos;
        end
        if (!button_now && deb_level) pressed_now = 1'b1;
        if (button_now && !deb_level) released_now = 1'b1;
        button_now = deb_level;
      end
      FUNC_GET_BUTTON: r.read_data = {15'b0, button_now};
      FUNC_GET_POS:    r.read_data = position_now;
      FUNC_ADD_OFFSET: count_now = count_now + it.offset;
      FUNC_SET_COLOR: begin
        duty_now[0] = level_to_duty(it.red_level);
        duty_now[1] = level_to_duty(it.green_level);
        duty_now[2] = level_to_duty(it.blue_level);
      end
      FUNC_GET_EVENT: begin
        // Button events win over position events.
        if (pressed_now || released_now) begin
          r.ev_valid = 1'b1;
          r.ev_code  = EVT_BUTTON;
          r.ev_data  = {7'b0, pressed_now, 7'b0, released_now};
          button_events++;
        end else if (pos_changed) begin
          r.ev_valid = 1'b1;
          r.ev_code  = EVT_POSITION;
          r.ev_data  = position_now;
          position_events++;
        end
      end
      FUNC_CLR_EVENT: begin
        if (it.clear_code == EVT_BUTTON) begin
          pressed_now  = 1'b0;
          released_now = 1'b0;
        end else begin
          pos_changed = 1'b0;
        end
      end
      default: begin
        count_now = '0;
        duty_now[0] = DUTY_OFF;
        duty_now[1] = DUTY_OFF;
        duty_now[2] = DUTY_OFF;
      end
    endcase
    r.duty_r = duty_now[0];
    r.duty_g = duty_now[1];
    r.duty_b = duty_now[2];
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= 50) $display("%0t ns: %s is 0x%0h, predicted 0x%0h", $time, what, got, want);
  endtask

  task automatic queue_sample(logic a, logic b, logic sw, logic [31:0] t);
    item_t it;
    it = '0;
    it.func    = FUNC_SAMPLE;
    it.pin_a   = a;
    it.pin_b   = b;
    it.pin_sw  = sw;
    it.time_us = t;
    beats_to_send.push_back(it);
    queued_beats++;
  endtask

  // The argument is the offset, the three color levels or the clear code, as the command needs.
  task automatic queue_cmd(func_t f, logic [23:0] arg);
    item_t it;
    it = '0;
    it.func = f;
    case (f)
      FUNC_ADD_OFFSET: it.offset = arg[15:0];
      FUNC_SET_COLOR:  {it.red_level, it.green_level, it.blue_level} = arg;
      FUNC_CLR_EVENT:  it.clear_code = arg[0];
      default: ;
    endcase
    beats_to_send.push_back(it);
    queued_beats++;
  endtask

  // Mostly clean knob turns and switch presses, with bus commands and pin noise mixed in.
  task automatic queue_random_beats(int n);
    item_t       it;
    logic [95:0] filler;
    int          pick;
    int          i;
    for (i = 0; i < n; i++) begin
      filler = {$urandom, $urandom, $urandom};
      it = filler[$bits(item_t)-1:0];
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        it.func = FUNC_SAMPLE;
        if ($urandom_range(0, 9) >= 2) begin
          if ($urandom_range(0, 7) == 0) turn_dir = -turn_dir;
          quad_phase = (quad_phase + turn_dir) & 3;
        end
        case (quad_phase)
          0:       {it.pin_a, it.pin_b} = 2'b00;
          1:       {it.pin_a, it.pin_b} = 2'b10;
          2:       {it.pin_a, it.pin_b} = 2'b11;
          default: {it.pin_a, it.pin_b} = 2'b01;
        endcase
        if ($urandom_range(0, 24) == 0) begin
          sw_level = ~sw_level;
          bounce_left = $urandom_range(0, 4);
        end
        it.pin_sw = sw_level;
        if (bounce_left > 0) begin
          bounce_left--;
          it.pin_sw = $urandom_range(0, 1);
        end
        stamp = stamp + $urandom_range(0, period_now / 4 + 3);
        if ($urandom_range(0, 7) == 0) stamp = stamp + period_now + $urandom_range(0, 3);
        it.time_us = stamp;
      end else if (pick < 90) begin
        it.func = func_t'($urandom_range(1, 7));
        if (it.func == FUNC_RESET && $urandom_range(0, 2) != 0) it.func = FUNC_GET_EVENT;
      end else begin
        // Raw noise: random pins and a random timestamp.
        it.func = FUNC_SAMPLE;
      end
      beats_to_send.push_back(it);
      queued_beats++;
    end
  endtask

  task automatic wait_drained();
    while (accepted_beats != queued_beats || replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_debounce(logic [PERIOD_W-1:0] value);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    period_now  = value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Sender: offers queued beats after a random gap per beat.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_beat) gap_left = $urandom_range(0, gap_max);
      if (!in_tvalid || in_beat) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (beats_to_send.size() != 0) begin
          offered_item = beats_to_send.pop_front();
          in_tdata  <= {4'b0, offered_item.clear_code, offered_item.blue_level,
                        offered_item.green_level, offered_item.red_level,
                        offered_item.offset, offered_item.time_us,
                        offered_item.pin_sw, offered_item.pin_b, offered_item.pin_a};
          in_tuser  <= offered_item.func;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall per beat, plus long hold-offs on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_granted != holds_asked) begin
      holds_granted++;
      hold_left = LONG_HOLD - 1;
      out_tready <= 1'b0;
    end else begin
      if (out_beat) stall_left = $urandom_range(0, stall_max);
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Monitor: predicts on every input beat and checks every result beat.
  always @(posedge clk) begin
    knob_result_t want;
    knob_result_t got;
    in_beat  <= rst_n && in_tvalid && in_tready;
    out_beat <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      replies_due.push_back(advance_knob(offered_item));
      accepted_beats++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        report_mismatch("result beat with nothing outstanding", 1, 0);
      end else begin
        want = replies_due.pop_front();
        got.ok        = out_tdata[0];
        got.read_data = out_tdata[16:1];
        got.ev_valid  = out_tdata[17];
        got.ev_code   = out_tuser;
        got.ev_data   = out_tdata[33:18];
        got.duty_r    = out_tdata[49:34];
        got.duty_g    = out_tdata[65:50];
        got.duty_b    = out_tdata[81:66];
        if (got.ok != want.ok) report_mismatch("ok", got.ok, want.ok);
        if (got.read_data != want.read_data)
          report_mismatch("read_data", got.read_data, want.read_data);
        if (got.ev_valid != want.ev_valid)
          report_mismatch("event_valid", got.ev_valid, want.ev_valid);
        if (got.ev_code != want.ev_code) report_mismatch("event_code", got.ev_code, want.ev_code);
        if (got.ev_data != want.ev_data) report_mismatch("event_data", got.ev_data, want.ev_data);
        if (got.duty_r != want.duty_r) report_mismatch("duty_red", got.duty_r, want.duty_r);
        if (got.duty_g != want.duty_g) report_mismatch("duty_green", got.duty_g, want.duty_g);
        if (got.duty_b != want.duty_b) report_mismatch("duty_blue", got.duty_b, want.duty_b);
      end
    end
  end

  // Watchdog: ends the run when no beat moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == STALL_LIMIT) begin
      $display("No beat moved for %0d cycles; %0d results outstanding.",
               STALL_LIMIT, replies_due.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Stimulus: reset, directed beats, then random phases at several debounce periods.
  initial begin
    int          phase;
    logic [19:0] period_pick;
    period_now   = PERIOD_RESET;
    prev_a       = 1'b0;
    count_now    = '0;
    position_now = '0;
    pos_changed  = 1'b0;
    deb_level    = 1'b0;
    change_start = '0;
    button_now   = 1'b0;
    pressed_now  = 1'b0;
    released_now = 1'b0;
    duty_now[0]  = DUTY_OFF;
    duty_now[1]  = DUTY_OFF;
    duty_now[2]  = DUTY_OFF;
    stamp        = '0;
    quad_phase   = 0;
    turn_dir     = 1;
    sw_level     = 1'b0;
    bounce_left  = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reads straight after reset, one detent each way, and a press right at the period.
    queue_cmd(FUNC_GET_BUTTON, '0);
    queue_cmd(FUNC_GET_POS, '0);
    queue_cmd(FUNC_GET_EVENT, '0);
    queue_sample(1'b1, 1'b0, 1'b0, 32'd0);
    queue_cmd(FUNC_GET_EVENT, '0);
    queue_sample(1'b0, 1'b0, 1'b0, 32'd200);
    queue_sample(1'b1, 1'b1, 1'b1, 32'd5000);
    queue_sample(1'b1, 1'b1, 1'b1, 32'd10200);
    queue_sample(1'b1, 1'b1, 1'b1, 32'd10201);
    queue_cmd(FUNC_GET_BUTTON, '0);
    // Button event first, then the position event, each cleared on its own.
    queue_cmd(FUNC_GET_EVENT, '0);
    queue_cmd(FUNC_CLR_EVENT, 24'(EVT_BUTTON));
    queue_cmd(FUNC_GET_EVENT, '0);
    queue_cmd(FUNC_CLR_EVENT, 24'(EVT_POSITION));
    queue_cmd(FUNC_GET_EVENT, '0);
    // Offset extremes take the count to its top value 0xFFFF.
    queue_cmd(FUNC_ADD_OFFSET, 24'h007FFF);
    queue_cmd(FUNC_ADD_OFFSET, 24'h008000);
    queue_sample(1'b0, 1'b0, 1'b1, 32'd10300);
    queue_cmd(FUNC_GET_POS, '0);
    queue_cmd(FUNC_SET_COLOR, 24'hFF0080);
    queue_cmd(FUNC_SET_COLOR, 24'h01FEFF);
    // The reset command leaves the reported position until the next sample.
    queue_cmd(FUNC_RESET, '0);
    queue_cmd(FUNC_GET_POS, '0);
    queue_sample(1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
    queue_cmd(FUNC_GET_EVENT, '0);
    wait_drained();

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin
          period_pick = '0;
          gap_max = 10;
          stall_max = 10;
        end
        1: begin
          period_pick = 20'd37;
          gap_max = 0;
          stall_max = 10;
        end
        2: begin
          period_pick = 20'($urandom_range(1, 3000));
          gap_max = 0;
          stall_max = 0;
        end
        3: begin
          period_pick = '1;
          gap_max = 10;
          stall_max = 0;
        end
        default: begin
          period_pick = PERIOD_RESET;
          gap_max = 10;
          stall_max = 10;
        end
      endcase
      write_debounce(period_pick);
      settings_used++;
      // Back-to-back beats against a long receiver hold-off fill the block.
      if (phase == 1) holds_asked++;
      queue_random_beats(PHASE_BEATS);
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (replies_due.size() != 0) report_mismatch("results never delivered", replies_due.size(), 0);
    $display("Sent %0d beats (%0d pin samples) over %0d debounce settings from 0 to 1048575 us.",
             accepted_beats, sample_beats, settings_used);
    $display("Event reads returned %0d button and %0d position events; %0d mismatches.",
             button_events, position_events, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### rotary_knob_controller.f
rtl/rkc_pkg.sv
rtl/rkc_encoder.sv
rtl/rkc_switch.sv
rtl/rkc_color.sv
rtl/rotary_knob_controller.sv
sim/rotary_knob_controller_tb.sv
